// ===== src/grey_image_convolution_assert.svh =====
// Assertion macros shared by the convolution block
`ifndef GREY_IMAGE_CONVOLUTION_ASSERT_SVH
`define GREY_IMAGE_CONVOLUTION_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define GIC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("grey_image_convolution: check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define GIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("grey_image_convolution: check failed");

`endif

// ===== src/gic_pkg.sv =====
// Shared types and constants of the greyscale convolution block
package gic_pkg;

    localparam int COEF_BITS  = 7;
    localparam int NUM_COEF   = 25;
    localparam int WORD_COEFS = 9;
    localparam int SUM_W      = 20;
    localparam int MAG_W      = 19;
    localparam int PIX_W      = 8;
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 6;
    localparam int REG_W      = 3;
    localparam int TAPK_W     = 5;

    localparam logic [TAPK_W-1:0] LAST_TAP_3 = 5'd8;
    localparam logic [TAPK_W-1:0] LAST_TAP_5 = 5'd24;
    localparam logic [2:0]        LAST_COL_3 = 3'd2;
    localparam logic [2:0]        LAST_COL_5 = 3'd4;
    localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;

    typedef enum logic [REG_W-1:0] {
        REG_KERNEL_FIVE,
        REG_DIVISOR,
        REG_OFFSET,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_COEF_WORD_A,
        REG_COEF_WORD_B,
        REG_COEF_WORD_C
    } t_reg_idx;

    typedef logic signed [COEF_BITS-1:0] t_coef;

    typedef struct packed {
        logic                       kernel_five;
        logic [7:0]                 divisor;
        logic [7:0]                 offset;
        logic [10:0]                image_width;
        logic [12:0]                image_height;
        t_coef [NUM_COEF-1:0]       coef;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTER,
        S_CLATCH,
        S_TAP,
        S_DRAIN,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic center_rd;
        logic center_lat;
        logic tap_issue;
        logic div_start;
        logic div_step;
        logic finish;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic emit_go;
        logic interior;
        logic tap_last;
        logic mac_busy;
        logic div_last;
    } t_dp_sts;

endpackage

// ===== src/gic_if.sv =====
// Stream channel interfaces for pixel items and result items
interface gic_in_if import gic_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output opcode, output pixel_in, input ready);
    modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

interface gic_out_if import gic_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

// ===== src/gic_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module gic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/gic_datapath.sv =====
// Datapath: pixel history, frame counters, multiply-accumulate and divider
module gic_datapath import gic_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_dp_cmd          i_cmd,
    input  logic             i_opcode,
    input  logic [PIX_W-1:0] i_pixel,
    output t_dp_sts          o_sts,
    output logic [PIX_W-1:0] o_pixel_out,
    output logic             o_frame_end
);

    localparam int DEPTH = 4 * MAX_WIDTH + 8;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int LW    = WW + 2;
    localparam int DCW   = $clog2(MAG_W);
    localparam int PRW   = PIX_W + COEF_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_V   = (AW + 1)'(DEPTH);

    logic [WW-1:0]  w;
    logic [HW-1:0]  h;
    logic [CW-1:0]  total;
    logic [1:0]     half;
    logic [LW-1:0]  half_w;
    logic [LW-1:0]  lag;
    logic [2:0]     last_col;
    logic [TAPK_W-1:0] last_tap;

    logic [CW-1:0]  r_in_cnt;
    logic [CW-1:0]  r_out_cnt;
    logic [AW-1:0]  r_in_ptr;
    logic [AW-1:0]  r_out_ptr;
    logic [XW-1:0]  r_out_x;
    logic [YW-1:0]  r_out_y;

    logic           restart;
    logic [CW-1:0]  in_base;
    logic [CW-1:0]  out_base;
    logic [CW-1:0]  in_next;
    logic           pix_go;
    logic           flush_go;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [AW-1:0]  raddr;
    logic [PIX_W-1:0] rd_data;

    logic [AW-1:0]  r_tap_addr;
    logic [TAPK_W-1:0] r_tap_k;
    logic [2:0]     r_tap_c;
    logic           r_rd_v;
    logic [TAPK_W-1:0] r_rd_k;
    logic signed [PRW-1:0]   r_prod;
    logic           r_prod_v;
    logic signed [SUM_W-1:0] r_acc;
    logic [PIX_W-1:0] r_val;

    logic [AW:0]    s1;
    logic [AW-1:0]  start1;
    logic [AW-1:0]  start2;
    logic [AW:0]    row_back;
    logic [AW-1:0]  up_addr;
    logic [AW-1:0]  fwd_addr;

    logic [MAG_W-1:0] r_div_n;
    logic [7:0]     r_div_rem;
    logic [DCW-1:0] r_div_cnt;
    logic           r_div_neg;
    logic [7:0]     d;
    logic [8:0]     rem_sh;
    logic           ge;
    logic [8:0]     rem_nx;
    logic signed [SUM_W-1:0] q;
    logic signed [SUM_W:0]   res;
    logic [PIX_W-1:0] clamped;

    logic [PIX_W-1:0] r_pix_out;
    logic           r_frame_end;

    always_comb begin
        if (i_cfg.image_width == '0) begin
            w = WW'(1);
        end else if (32'(i_cfg.image_width) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(i_cfg.image_width);
        end
        if (i_cfg.image_height == '0) begin
            h = HW'(1);
        end else if (32'(i_cfg.image_height) > MAX_HEIGHT) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(i_cfg.image_height);
        end
        total    = CW'(CW'(w) * CW'(h));
        half     = i_cfg.kernel_five ? 2'd2 : 2'd1;
        half_w   = i_cfg.kernel_five ? (LW'(w) << 1) : LW'(w);
        lag      = half_w + LW'(half);
        last_col = i_cfg.kernel_five ? LAST_COL_5 : LAST_COL_3;
        last_tap = i_cfg.kernel_five ? LAST_TAP_5 : LAST_TAP_3;
    end

    always_comb begin
        restart  = r_in_cnt >= total;
        in_base  = restart ? '0 : r_in_cnt;
        out_base = restart ? '0 : r_out_cnt;
        in_next  = in_base + 1'b1;
        pix_go   = ((CW + 1)'(in_next) > (CW + 1)'(out_base) + (CW + 1)'(lag))
                   && (out_base < total);
        flush_go = restart && (r_out_cnt < total);
        we       = i_cmd.accept && !i_opcode;
        waddr    = restart ? '0 : r_in_ptr;
        raddr    = i_cmd.center_rd ? r_out_ptr : r_tap_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
            r_in_ptr  <= '0;
            r_out_ptr <= '0;
            r_out_x   <= '0;
            r_out_y   <= '0;
        end else begin
            if (we) begin
                r_in_cnt <= in_next;
                r_in_ptr <= (waddr == LAST_ADDR) ? '0 : waddr + 1'b1;
                if (restart) begin
                    r_out_cnt <= '0;
                    r_out_ptr <= '0;
                    r_out_x   <= '0;
                    r_out_y   <= '0;
                end
            end
            if (i_cmd.emit) begin
                r_out_cnt <= r_out_cnt + 1'b1;
                r_out_ptr <= (r_out_ptr == LAST_ADDR) ? '0 : r_out_ptr + 1'b1;
                if (32'(r_out_x) + 1 == 32'(w)) begin
                    r_out_x <= '0;
                    r_out_y <= r_out_y + 1'b1;
                end else begin
                    r_out_x <= r_out_x + 1'b1;
                end
            end
        end
    end

    gic_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_pixel),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    always_comb begin
        s1       = (AW + 1)'(r_out_ptr) + (AW + 1)'(half_w);
        start1   = (s1 >= DEPTH_V) ? AW'(s1 - DEPTH_V) : AW'(s1);
        start2   = (r_tap_addr >= AW'(half)) ? r_tap_addr - AW'(half)
                   : AW'((AW + 1)'(r_tap_addr) + DEPTH_V - (AW + 1)'(half));
        row_back = (AW + 1)'(w) + (AW + 1)'(last_col);
        up_addr  = ((AW + 1)'(r_tap_addr) >= row_back)
                   ? AW'((AW + 1)'(r_tap_addr) - row_back)
                   : AW'((AW + 1)'(r_tap_addr) + DEPTH_V - row_back);
        fwd_addr = (r_tap_addr == LAST_ADDR) ? '0 : r_tap_addr + 1'b1;
    end

    always_comb begin
        d       = (i_cfg.divisor == '0) ? 8'd1 : i_cfg.divisor;
        rem_sh  = {r_div_rem, r_div_n[MAG_W-1]};
        ge      = rem_sh >= {1'b0, d};
        rem_nx  = ge ? rem_sh - {1'b0, d} : rem_sh;
        q       = r_div_neg ? -$signed({1'b0, r_div_n}) : $signed({1'b0, r_div_n});
        res     = (SUM_W + 1)'(q) + $signed((SUM_W + 1)'(i_cfg.offset));
        if (res <= 0) begin
            clamped = '0;
        end else if (res >= $signed((SUM_W + 1)'(PIX_MAX))) begin
            clamped = PIX_MAX;
        end else begin
            clamped = res[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= i_cmd.tap_issue;
            r_prod_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_k <= r_tap_k;
        if (i_cmd.center_rd) begin
            r_tap_addr <= start1;
        end
        if (i_cmd.center_lat) begin
            r_tap_addr <= start2;
            r_tap_k    <= '0;
            r_tap_c    <= '0;
            r_val      <= rd_data;
            r_acc      <= '0;
        end
        if (i_cmd.tap_issue) begin
            r_tap_k <= r_tap_k + 1'b1;
            if (r_tap_c == last_col) begin
                r_tap_c    <= '0;
                r_tap_addr <= up_addr;
            end else begin
                r_tap_c    <= r_tap_c + 1'b1;
                r_tap_addr <= fwd_addr;
            end
        end
        if (r_rd_v) begin
            r_prod <= $signed({1'b0, rd_data}) * i_cfg.coef[r_rd_k];
        end
        if (r_prod_v) begin
            r_acc <= r_acc + SUM_W'(r_prod);
        end
        if (i_cmd.div_start) begin
            r_div_n   <= MAG_W'(r_acc[SUM_W-1] ? -r_acc : r_acc);
            r_div_neg <= r_acc[SUM_W-1];
            r_div_rem <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_n   <= {r_div_n[MAG_W-2:0], ge};
            r_div_rem <= rem_nx[7:0];
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.finish) begin
            r_val <= clamped;
        end
        if (i_cmd.emit) begin
            r_pix_out   <= r_val;
            r_frame_end <= (r_out_cnt + 1'b1) == total;
        end
    end

    always_comb begin
        o_sts.emit_go  = i_opcode ? flush_go : pix_go;
        o_sts.interior = (32'(r_out_x) >= 32'(half))
                         && (32'(r_out_x) + 32'(half) < 32'(w))
                         && (32'(r_out_y) >= 32'(half))
                         && (32'(r_out_y) + 32'(half) < 32'(h));
        o_sts.tap_last = r_tap_k == last_tap;
        o_sts.mac_busy = r_rd_v || r_prod_v;
        o_sts.div_last = r_div_cnt == DCW'(MAG_W - 1);
    end

    assign o_pixel_out = r_pix_out;
    assign o_frame_end = r_frame_end;

endmodule

// ===== src/gic_ctrl.sv =====
// Controller state machine sequencing store, taps, divide and output
module gic_ctrl import gic_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.emit_go) begin
                        n_state = S_CENTER;
                    end
                end
            end
            S_CENTER: begin
                o_cmd.center_rd = 1'b1;
                n_state = S_CLATCH;
            end
            S_CLATCH: begin
                o_cmd.center_lat = 1'b1;
                n_state = i_sts.interior ? S_TAP : S_OUT;
            end
            S_TAP: begin
                o_cmd.tap_issue = 1'b1;
                if (i_sts.tap_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.mac_busy) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/grey_image_convolution.sv =====
// Top level: 3x3 or 5x5 greyscale convolution with APB register port.
// Pixels enter in raster order; each result pixel is produced half*width+half
// items after its own input, and flush items drain the rest once the frame is
// in. An item that yields no result leaves the controller idle. A border pixel
// goes from acceptance through the center read and center latch states to the
// output state. An interior pixel adds the tap, drain, divide and finish states:
// one history RAM read per tap through a single shared multiply-accumulate unit,
// then a 19-step bit-serial divider. A finished result waits in the output
// register while the next item is accepted.
`include "grey_image_convolution_assert.svh"
module grey_image_convolution import gic_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gic_in_if.sink            i_pix,
    gic_out_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic        r_kernel_five;
    logic [7:0]  r_divisor;
    logic [7:0]  r_offset;
    logic [10:0] r_image_width;
    logic [12:0] r_image_height;
    logic [62:0] r_coef_word_a;
    logic [62:0] r_coef_word_b;
    logic [62:0] r_coef_word_c;

    t_reg_idx          reg_idx;
    logic              wr;
    logic [2:0][62:0]  coef_words;
    t_cfg              cfg;
    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic              in_ready;
    logic              out_valid;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:ADDR_W-REG_W]);
    assign wr      = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_five  <= 1'b0;
            r_divisor      <= 8'd1;
            r_offset       <= '0;
            r_image_width  <= 11'd5;
            r_image_height <= 13'd5;
            r_coef_word_a  <= '0;
            r_coef_word_b  <= '0;
            r_coef_word_c  <= '0;
        end else if (wr) begin
            unique case (reg_idx)
                REG_KERNEL_FIVE:  r_kernel_five  <= pwdata[0];
                REG_DIVISOR:      r_divisor      <= pwdata[7:0];
                REG_OFFSET:       r_offset       <= pwdata[7:0];
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[10:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[12:0];
                REG_COEF_WORD_A:  r_coef_word_a  <= pwdata[62:0];
                REG_COEF_WORD_B:  r_coef_word_b  <= pwdata[62:0];
                REG_COEF_WORD_C:  r_coef_word_c  <= pwdata[62:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KERNEL_FIVE:  prdata = DATA_W'(r_kernel_five);
            REG_DIVISOR:      prdata = DATA_W'(r_divisor);
            REG_OFFSET:       prdata = DATA_W'(r_offset);
            REG_IMAGE_WIDTH:  prdata = DATA_W'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(r_image_height);
            REG_COEF_WORD_A:  prdata = DATA_W'(r_coef_word_a);
            REG_COEF_WORD_B:  prdata = DATA_W'(r_coef_word_b);
            REG_COEF_WORD_C:  prdata = DATA_W'(r_coef_word_c);
        endcase
    end

    assign coef_words       = {r_coef_word_c, r_coef_word_b, r_coef_word_a};
    assign cfg.kernel_five  = r_kernel_five;
    assign cfg.divisor      = r_divisor;
    assign cfg.offset       = r_offset;
    assign cfg.image_width  = r_image_width;
    assign cfg.image_height = r_image_height;

    for (genvar k = 0; k < NUM_COEF; k++) begin : g_coef
        assign cfg.coef[k] =
            coef_words[k / WORD_COEFS][(k % WORD_COEFS) * COEF_BITS +: COEF_BITS];
    end

    gic_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_opcode    (i_pix.opcode),
        .i_pixel     (i_pix.pixel_in),
        .o_sts       (sts),
        .o_pixel_out (o_res.pixel_out),
        .o_frame_end (o_res.frame_end)
    );

    gic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    assign i_pix.ready = in_ready;
    assign o_res.valid = out_valid;

    `GIC_ASSERT_SAME(a_emit_slot_free, cmd.emit, !o_res.valid || o_res.ready)
    `GIC_ASSERT_NEXT(a_accept_no_emit, cmd.accept, !cmd.emit)
    `GIC_ASSERT_NEXT(a_quiet_item_ready, cmd.accept && !sts.emit_go, i_pix.ready)

endmodule
